### hdl/pid_heading_to_target_defines.svh
// assertion macros for the heading-to-target controller
`ifndef PID_HEADING_TO_TARGET_DEFINES_SVH
`define PID_HEADING_TO_TARGET_DEFINES_SVH

`ifndef SYNTHESIS
`define PHT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PHT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hdl/pht_pkg.sv
// shared types, constants and the arctangent table of the heading controller
`timescale 1ns / 1ps
`default_nettype none

package pht_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam int POS_W   = 16;
    localparam int ANG_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int LEN_W   = 15;
    localparam int RATE_W  = 24;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 17;
    localparam int DER_W   = 18;
    localparam int SUM_W   = 32;
    localparam int CW      = 34;
    localparam int MA_W    = 25;
    localparam int MB_W    = 32;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int DIST_W  = 34;
    localparam int ATAN_IDX_W = 5;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_GOAL_X        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GOAL_Y        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ARRIVE_RADIUS = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CRUISE_SPEED  = 3'd6;

    localparam logic [POS_W-1:0]  RST_GOAL_X        = 16'd2048;
    localparam logic [POS_W-1:0]  RST_GOAL_Y        = 16'd2048;
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN     = 24'd262144;
    localparam logic [GAIN_W-1:0] RST_INTEGRAL_GAIN = 24'd655;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN    = 24'd98304;
    localparam logic [LEN_W-1:0]  RST_ARRIVE_RADIUS = 15'd128;
    localparam logic [LEN_W-1:0]  RST_CRUISE_SPEED  = 15'd512;

    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_DXDX = 3'd0;
    localparam t_mul_sel MUL_DYDY = 3'd1;
    localparam t_mul_sel MUL_RR   = 3'd2;
    localparam t_mul_sel MUL_KP   = 3'd3;
    localparam t_mul_sel MUL_KI   = 3'd4;
    localparam t_mul_sel MUL_KD   = 3'd5;

    typedef logic signed [CW-1:0] t_cord;

    typedef struct packed {
        logic [POS_W-1:0]  goal_x;
        logic [POS_W-1:0]  goal_y;
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integral_gain;
        logic [GAIN_W-1:0] derivative_gain;
        logic [LEN_W-1:0]  arrive_radius;
        logic [LEN_W-1:0]  cruise_speed;
    } t_cfg;

    typedef struct packed {
        logic     load_in;
        logic     cordic_init;
        logic     cordic_step;
        t_mul_sel mul_sel;
        logic     dist_load;
        logic     dist_add;
        logic     err_update;
        logic     acc_load;
        logic     acc_add;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic iter_last;
    } t_stat;

    // atan(2^-i) in Q2.30, truncated
    function automatic t_cord atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        t_cord v;
        unique case (idx)
            5'd0:    v = CW'(32'h3243F6A8);
            5'd1:    v = CW'(32'h1DAC6705);
            5'd2:    v = CW'(32'h0FADBAFC);
            5'd3:    v = CW'(32'h07F56EA6);
            5'd4:    v = CW'(32'h03FEAB76);
            5'd5:    v = CW'(32'h01FFD55B);
            5'd6:    v = CW'(32'h00FFFAAA);
            5'd7:    v = CW'(32'h007FFF55);
            5'd8:    v = CW'(32'h003FFFEA);
            5'd9:    v = CW'(32'h001FFFFD);
            5'd10:   v = CW'(32'h000FFFFF);
            5'd11:   v = CW'(32'h0007FFFF);
            5'd12:   v = CW'(32'h0003FFFF);
            5'd13:   v = CW'(32'h0001FFFF);
            5'd14:   v = CW'(32'h0000FFFF);
            5'd15:   v = CW'(32'h00007FFF);
            5'd16:   v = CW'(32'h00003FFF);
            5'd17:   v = CW'(32'h00001FFF);
            5'd18:   v = CW'(32'h00000FFF);
            5'd19:   v = CW'(32'h000007FF);
            5'd20:   v = CW'(32'h000003FF);
            5'd21:   v = CW'(32'h000001FF);
            5'd22:   v = CW'(32'h000000FF);
            5'd23:   v = CW'(32'h0000007F);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hdl/pid_heading_to_target.sv
// top level of the go-to-goal heading controller
//
//   port group     dir   handshake              payload
//   pose in        in    i_in_valid/o_in_ready  i_x_pos, i_y_pos, i_heading
//   command out    out   o_out_valid/i_out_ready o_linear_speed, o_angular_rate,
//                                               o_target_reached, o_heading_error
//   registers      in    apb psel/penable       paddr, pwdata, prdata
//
// a pose is taken in idle, then passes prep, the cordic iterations, the distance squares,
// the error update, the pid products and a last sum before its result is loaded for output
// the cordic unit runs one iteration per cycle, then one shared multiplier takes the
// two squares, the radius square and the three pid terms in turn
// a finished result sits in the output register; the next pose is taken while it waits
// synchronous active-low reset clears the sequencer, the error sum and the last error
`timescale 1ns / 1ps
`default_nettype none

module pid_heading_to_target import pht_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire         [POS_W-1:0]   i_x_pos,
    input  wire         [POS_W-1:0]   i_y_pos,
    input  wire         [ANG_W-1:0]   i_heading,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output logic        [LEN_W-1:0]   o_linear_speed,
    output logic signed [RATE_W-1:0]  o_angular_rate,
    output logic                      o_target_reached,
    output logic signed [ERR_W-1:0]   o_heading_error,
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire         [APB_ADDR_W-1:0] paddr,
    input  wire         [APB_DATA_W-1:0] pwdata,
    output logic        [APB_DATA_W-1:0] prdata,
    output logic                      pready
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    pht_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pht_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg            (cfg),
        .i_x_pos          (i_x_pos),
        .i_y_pos          (i_y_pos),
        .i_heading        (i_heading),
        .o_linear_speed   (o_linear_speed),
        .o_angular_rate   (o_angular_rate),
        .o_target_reached (o_target_reached),
        .o_heading_error  (o_heading_error)
    );

endmodule

`default_nettype wire

### hdl/pht_regs.sv
// configuration register file behind the apb port
`timescale 1ns / 1ps
`default_nettype none

module pht_regs import pht_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_ADDR_W-1:0] paddr,
    input  wire  [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_x          <= RST_GOAL_X;
            r_cfg.goal_y          <= RST_GOAL_Y;
            r_cfg.prop_gain       <= RST_PROP_GAIN;
            r_cfg.integral_gain   <= RST_INTEGRAL_GAIN;
            r_cfg.derivative_gain <= RST_DERIV_GAIN;
            r_cfg.arrive_radius   <= RST_ARRIVE_RADIUS;
            r_cfg.cruise_speed    <= RST_CRUISE_SPEED;
        end else if (wr_en) begin
            unique case (idx)
                REG_GOAL_X:        r_cfg.goal_x          <= pwdata[POS_W-1:0];
                REG_GOAL_Y:        r_cfg.goal_y          <= pwdata[POS_W-1:0];
                REG_PROP_GAIN:     r_cfg.prop_gain       <= pwdata[GAIN_W-1:0];
                REG_INTEGRAL_GAIN: r_cfg.integral_gain   <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN:    r_cfg.derivative_gain <= pwdata[GAIN_W-1:0];
                REG_ARRIVE_RADIUS: r_cfg.arrive_radius   <= pwdata[LEN_W-1:0];
                REG_CRUISE_SPEED:  r_cfg.cruise_speed    <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_GOAL_X:        prdata = APB_DATA_W'(r_cfg.goal_x);
            REG_GOAL_Y:        prdata = APB_DATA_W'(r_cfg.goal_y);
            REG_PROP_GAIN:     prdata = APB_DATA_W'(r_cfg.prop_gain);
            REG_INTEGRAL_GAIN: prdata = APB_DATA_W'(r_cfg.integral_gain);
            REG_DERIV_GAIN:    prdata = APB_DATA_W'(r_cfg.derivative_gain);
            REG_ARRIVE_RADIUS: prdata = APB_DATA_W'(r_cfg.arrive_radius);
            REG_CRUISE_SPEED:  prdata = APB_DATA_W'(r_cfg.cruise_speed);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/pht_ctrl.sv
// sequencing state machine and output handshake of the heading controller
`timescale 1ns / 1ps
`default_nettype none
`include "pid_heading_to_target_defines.svh"

module pht_ctrl import pht_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  wire   i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_ITER = 4'd2;
    localparam logic [3:0] S_MDX  = 4'd3;
    localparam logic [3:0] S_MDY  = 4'd4;
    localparam logic [3:0] S_MRR  = 4'd5;
    localparam logic [3:0] S_ERR  = 4'd6;
    localparam logic [3:0] S_MP   = 4'd7;
    localparam logic [3:0] S_MI   = 4'd8;
    localparam logic [3:0] S_MD   = 4'd9;
    localparam logic [3:0] S_MA   = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_ovalid;
    logic       n_ovalid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.cordic_init = 1'b1;
                n_state           = S_ITER;
            end
            S_ITER: begin
                o_cmd.cordic_step = 1'b1;
                if (i_stat.iter_last) begin
                    n_state = S_MDX;
                end
            end
            S_MDX: begin
                o_cmd.mul_sel = MUL_DXDX;
                n_state       = S_MDY;
            end
            S_MDY: begin
                o_cmd.mul_sel   = MUL_DYDY;
                o_cmd.dist_load = 1'b1;
                n_state         = S_MRR;
            end
            S_MRR: begin
                o_cmd.mul_sel  = MUL_RR;
                o_cmd.dist_add = 1'b1;
                n_state        = S_ERR;
            end
            S_ERR: begin
                o_cmd.err_update = 1'b1;
                n_state          = S_MP;
            end
            S_MP: begin
                o_cmd.mul_sel = MUL_KP;
                n_state       = S_MI;
            end
            S_MI: begin
                o_cmd.mul_sel  = MUL_KI;
                o_cmd.acc_load = 1'b1;
                n_state        = S_MD;
            end
            S_MD: begin
                o_cmd.mul_sel = MUL_KD;
                o_cmd.acc_add = 1'b1;
                n_state       = S_MA;
            end
            S_MA: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    `PHT_ASSERT(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load |-> (!r_ovalid || i_out_ready), "result overwritten before transfer")
    `PHT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input taken while busy")
    `PHT_ASSERT_NEXT(a_valid_after_load, i_clk, i_rst_n, o_cmd.out_load, o_out_valid, "loaded result not shown")
    `PHT_ASSERT(a_one_phase, i_clk, i_rst_n, $onehot0({o_cmd.load_in, o_cmd.cordic_init, o_cmd.cordic_step, o_cmd.err_update, o_cmd.out_load}), "conflicting datapath commands")

endmodule

`default_nettype wire

### hdl/pht_dp.sv
// datapath: cordic bearing, distance test, pid with shared multiplier, result register
`timescale 1ns / 1ps
`default_nettype none

module pht_dp import pht_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  t_cmd                      i_cmd,
    output t_stat                     o_stat,
    input  t_cfg                      i_cfg,
    input  wire         [POS_W-1:0]   i_x_pos,
    input  wire         [POS_W-1:0]   i_y_pos,
    input  wire         [ANG_W-1:0]   i_heading,
    output logic        [LEN_W-1:0]   o_linear_speed,
    output logic signed [RATE_W-1:0]  o_angular_rate,
    output logic                      o_target_reached,
    output logic signed [ERR_W-1:0]   o_heading_error
);

    localparam int ITER_W   = $clog2(CORDIC_STEPS);
    localparam int SCALE    = 14;
    localparam int Z_SHIFT  = 18;
    localparam int R_SHIFT  = 16;
    localparam int SH_W     = ACC_W - R_SHIFT;
    localparam t_cord Z_RND = t_cord'(1) <<< (Z_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] A_RND = ACC_W'(1) <<< (R_SHIFT - 1);

    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic signed [ANG_W-1:0]  r_hd;
    logic                     r_zero;
    t_cord                    r_x;
    t_cord                    r_y;
    t_cord                    r_z;
    logic [ITER_W-1:0]        r_iter;
    logic signed [PROD_W-1:0] r_prod;
    logic [DIST_W-1:0]        r_dist;
    logic                     r_reach;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [ERR_W-1:0]  r_last;
    logic signed [DER_W-1:0]  r_deriv;
    logic signed [ACC_W-1:0]  r_acc;
    logic [LEN_W-1:0]         r_lin;
    logic signed [RATE_W-1:0] r_rate;
    logic                     r_rchd;
    logic signed [ERR_W-1:0]  r_herr;

    t_cord x0, y0, xi, yi, zi, xs, ys, xn, yn, zn, ang, pi_half2, zr;
    logic signed [ANG_W-1:0]  bear;
    logic signed [ERR_W-1:0]  e;
    logic signed [SUM_W:0]    s_wide;
    logic signed [SUM_W-1:0]  s_sat;
    logic signed [DER_W-1:0]  deriv;
    logic signed [MA_W-1:0]   ma;
    logic signed [MB_W-1:0]   mb;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [SH_W-1:0]   sh;
    logic signed [RATE_W-1:0] rate;

    assign o_stat.iter_last = (r_iter == ITER_W'(CORDIC_STEPS - 1));

    // quadrant pre-rotation for vectors in the left half plane
    always_comb begin
        x0       = t_cord'(r_dx) <<< SCALE;
        y0       = t_cord'(r_dy) <<< SCALE;
        pi_half2 = atan_q30('0) <<< 1;
        xi       = x0;
        yi       = y0;
        zi       = '0;
        if (r_dx[DIFF_W-1]) begin
            if (!r_dy[DIFF_W-1]) begin
                xi = y0;
                yi = -x0;
                zi = pi_half2;
            end else begin
                xi = -y0;
                yi = x0;
                zi = -pi_half2;
            end
        end
    end

    // one vectoring iteration
    always_comb begin
        xs  = r_x >>> r_iter;
        ys  = r_y >>> r_iter;
        ang = atan_q30(ATAN_IDX_W'(r_iter));
        if (!r_y[CW-1]) begin
            xn = r_x + ys;
            yn = r_y - xs;
            zn = r_z + ang;
        end else begin
            xn = r_x - ys;
            yn = r_y + xs;
            zn = r_z - ang;
        end
    end

    // heading error, saturating integral, difference
    always_comb begin
        zr     = r_z + Z_RND;
        bear   = r_zero ? '0 : zr[Z_SHIFT+ANG_W-1:Z_SHIFT];
        e      = ERR_W'(bear) - ERR_W'(r_hd);
        s_wide = (SUM_W+1)'(r_sum) + (SUM_W+1)'(e);
        if (s_wide[SUM_W] != s_wide[SUM_W-1]) begin
            s_sat = s_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            s_sat = s_wide[SUM_W-1:0];
        end
        deriv = DER_W'(e) - DER_W'(r_last);
    end

    // shared multiplier operands
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_DXDX: begin
                ma = MA_W'(r_dx);
                mb = MB_W'(r_dx);
            end
            MUL_DYDY: begin
                ma = MA_W'(r_dy);
                mb = MB_W'(r_dy);
            end
            MUL_RR: begin
                ma = MA_W'({1'b0, i_cfg.arrive_radius});
                mb = MB_W'({1'b0, i_cfg.arrive_radius});
            end
            MUL_KP: begin
                ma = MA_W'({1'b0, i_cfg.prop_gain});
                mb = MB_W'(r_last);
            end
            MUL_KI: begin
                ma = MA_W'({1'b0, i_cfg.integral_gain});
                mb = r_sum;
            end
            MUL_KD: begin
                ma = MA_W'({1'b0, i_cfg.derivative_gain});
                mb = MB_W'(r_deriv);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // round to q.12 and saturate the rate
    always_comb begin
        acc_rnd = r_acc + A_RND;
        sh      = acc_rnd[ACC_W-1:R_SHIFT];
        if (sh[SH_W-1:RATE_W-1] != {(SH_W-RATE_W+1){sh[SH_W-1]}}) begin
            rate = sh[SH_W-1] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
        end else begin
            rate = sh[RATE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        if (i_cmd.load_in) begin
            r_dx <= DIFF_W'(signed'(i_cfg.goal_x)) - DIFF_W'(signed'(i_x_pos));
            r_dy <= DIFF_W'(signed'(i_cfg.goal_y)) - DIFF_W'(signed'(i_y_pos));
            r_hd <= i_heading;
        end
        if (i_cmd.cordic_init) begin
            r_x    <= xi;
            r_y    <= yi;
            r_z    <= zi;
            r_iter <= '0;
            r_zero <= (r_dx == '0) && (r_dy == '0);
        end
        if (i_cmd.cordic_step) begin
            r_x    <= xn;
            r_y    <= yn;
            r_z    <= zn;
            r_iter <= r_iter + 1'b1;
        end
        if (i_cmd.dist_load) begin
            r_dist <= r_prod[DIST_W-1:0];
        end
        if (i_cmd.dist_add) begin
            r_dist <= r_dist + r_prod[DIST_W-1:0];
        end
        if (i_cmd.err_update) begin
            r_reach <= (r_dist <= r_prod[DIST_W-1:0]);
            r_deriv <= deriv;
        end
        if (i_cmd.acc_load) begin
            r_acc <= ACC_W'(r_prod);
        end
        if (i_cmd.acc_add) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.out_load) begin
            r_lin  <= r_reach ? '0 : i_cfg.cruise_speed;
            r_rate <= r_reach ? '0 : rate;
            r_rchd <= r_reach;
            r_herr <= r_last;
        end
    end

    // controller memory across items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (i_cmd.err_update) begin
            r_sum  <= s_sat;
            r_last <= e;
        end
    end

    assign o_linear_speed   = r_lin;
    assign o_angular_rate   = r_rate;
    assign o_target_reached = r_rchd;
    assign o_heading_error  = r_herr;

endmodule

`default_nettype wire

### bench/pid_heading_to_target_test.sv
// self-checking testbench of the go-to-goal heading controller
`timescale 1ns / 1ps

module pid_heading_to_target_test;
    import pht_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [ANG_W-1:0] heading;
    } t_pose;

    typedef struct packed {
        logic        [LEN_W-1:0]  lin_speed;
        logic signed [RATE_W-1:0] ang_rate;
        logic                     reached;
        logic signed [ERR_W-1:0]  hdg_err;
    } t_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_pose in_pose = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic        [LEN_W-1:0]  lin_speed;
    logic signed [RATE_W-1:0] ang_rate;
    logic                     reached;
    logic signed [ERR_W-1:0]  hdg_err;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    t_pose   pose_q[$];
    t_result cmd_expect_q[$];
    t_result oldest_cmd;
    t_cfg  cfg_copy;
    longint err_sum = 0;
    longint prev_err = 0;
    int mismatch_cnt = 0;
    int src_idle_pct = 35;
    int sink_idle_pct = 35;
    int hold_len = 0;
    int hold_left = 0;
    logic hold_token = 1'b0;
    logic hold_seen = 1'b0;

    longint atan_tab [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    always #2 clk = ~clk;

    pid_heading_to_target #(
        .CORDIC_STEPS(STEPS)
    ) u_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_x_pos(in_pose.x),
        .i_y_pos(in_pose.y),
        .i_heading(in_pose.heading),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_linear_speed(lin_speed),
        .o_angular_rate(ang_rate),
        .o_target_reached(reached),
        .o_heading_error(hdg_err),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // vectoring cordic atan2, result in Q4.12 radians
    function automatic longint bearing_q12(input longint dx, input longint dy);
        longint x, y, z, t, xs, ys;
        int i;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx * 16384;
        y = dy * 16384;
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t;
                z = 2 * atan_tab[0];
            end else begin
                t = x; x = -y; y = t;
                z = -2 * atan_tab[0];
            end
        end
        for (i = 0; i < STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + atan_tab[i];
            end else begin
                x = x - ys; y = y + xs; z = z - atan_tab[i];
            end
        end
        return (z + 64'sd131072) >>> 18;
    endfunction

    // advances the pid state by one pose and returns the command it yields
    function automatic t_result steer_predict(input t_pose p);
        longint dx, dy, d2, r2, err, deriv, acc, rate;
        t_result c;
        dx = longint'($signed(cfg_copy.goal_x)) - longint'($signed(p.x));
        dy = longint'($signed(cfg_copy.goal_y)) - longint'($signed(p.y));
        d2 = dx * dx + dy * dy;
        r2 = longint'(cfg_copy.arrive_radius) * longint'(cfg_copy.arrive_radius);
        err = bearing_q12(dx, dy) - longint'($signed(p.heading));
        err_sum = err_sum + err;
        if (err_sum > 64'sd2147483647)
            err_sum = 64'sd2147483647;
        if (err_sum < -64'sd2147483648)
            err_sum = -64'sd2147483648;
        deriv = err - prev_err;
        prev_err = err;
        acc = longint'(cfg_copy.prop_gain) * err + longint'(cfg_copy.integral_gain) * err_sum
            + longint'(cfg_copy.derivative_gain) * deriv;
        rate = (acc + 64'sd32768) >>> 16;
        if (rate > 64'sd8388607)
            rate = 64'sd8388607;
        if (rate < -64'sd8388608)
            rate = -64'sd8388608;
        c.reached = (d2 <= r2);
        c.lin_speed = c.reached ? '0 : cfg_copy.cruise_speed;
        c.ang_rate = c.reached ? '0 : rate[RATE_W-1:0];
        c.hdg_err = err[ERR_W-1:0];
        return c;
    endfunction

    // pose source
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                cmd_expect_q.push_back(steer_predict(in_pose));
            if (!in_valid || in_ready) begin
                if (pose_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    in_pose <= pose_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // command sink with random stalls and a long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= hold_len;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // command checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (cmd_expect_q.size() == 0) begin
                $error("command transfer with nothing expected");
                mismatch_cnt++;
            end else begin
                oldest_cmd = cmd_expect_q.pop_front();
                if (lin_speed !== oldest_cmd.lin_speed) begin
                    $error("linear_speed expected %0d got %0d", oldest_cmd.lin_speed, lin_speed);
                    mismatch_cnt++;
                end
                if (ang_rate !== oldest_cmd.ang_rate) begin
                    $error("angular_rate expected %0d got %0d",
                        $signed(oldest_cmd.ang_rate), $signed(ang_rate));
                    mismatch_cnt++;
                end
                if (reached !== oldest_cmd.reached) begin
                    $error("target_reached expected %0d got %0d", oldest_cmd.reached, reached);
                    mismatch_cnt++;
                end
                if (hdg_err !== oldest_cmd.hdg_err) begin
                    $error("heading_error expected %0d got %0d",
                        $signed(oldest_cmd.hdg_err), $signed(hdg_err));
                    mismatch_cnt++;
                end
            end
        end
    end

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GOAL_X:        cfg_copy.goal_x = val[POS_W-1:0];
            REG_GOAL_Y:        cfg_copy.goal_y = val[POS_W-1:0];
            REG_PROP_GAIN:     cfg_copy.prop_gain = val[GAIN_W-1:0];
            REG_INTEGRAL_GAIN: cfg_copy.integral_gain = val[GAIN_W-1:0];
            REG_DERIV_GAIN:    cfg_copy.derivative_gain = val[GAIN_W-1:0];
            REG_ARRIVE_RADIUS: cfg_copy.arrive_radius = val[LEN_W-1:0];
            REG_CRUISE_SPEED:  cfg_copy.cruise_speed = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] tx, input logic [15:0] ty,
                              input logic [23:0] kp, input logic [23:0] ki,
                              input logic [23:0] kd, input logic [14:0] rad,
                              input logic [14:0] spd);
        reg_write(REG_GOAL_X, {16'd0, tx});
        reg_write(REG_GOAL_Y, {16'd0, ty});
        reg_write(REG_PROP_GAIN, {8'd0, kp});
        reg_write(REG_INTEGRAL_GAIN, {8'd0, ki});
        reg_write(REG_DERIV_GAIN, {8'd0, kd});
        reg_write(REG_ARRIVE_RADIUS, {17'd0, rad});
        reg_write(REG_CRUISE_SPEED, {17'd0, spd});
    endtask

    task automatic rand_config(input bit no_integral);
        logic [23:0] ki;
        logic [14:0] rad;
        ki = no_integral ? 24'd0 : ($urandom_range(1) ? 24'($urandom) : 24'($urandom_range(0, 4095)));
        rad = $urandom_range(1) ? 15'($urandom) : 15'($urandom_range(0, 1024));
        set_config(16'($urandom), 16'($urandom), 24'($urandom), ki, 24'($urandom), rad,
            15'($urandom));
    endtask

    task automatic add_pose(input int x, input int y, input int h);
        t_pose p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.heading = 16'(h);
        pose_q.push_back(p);
    endtask

    function automatic t_pose rand_pose();
        int kind, span;
        t_pose p;
        kind = $urandom_range(99);
        if (kind < 40) begin
            p.x = 16'($urandom);
            p.y = 16'($urandom);
        end else begin
            span = (kind < 75) ? int'(cfg_copy.arrive_radius) + 4 : 4096;
            p.x = cfg_copy.goal_x + 16'(int'($urandom_range(0, 2 * span)) - span);
            p.y = cfg_copy.goal_y + 16'(int'($urandom_range(0, 2 * span)) - span);
        end
        p.heading = $urandom_range(1) ? 16'($urandom)
                                      : 16'(int'($urandom_range(0, 25736)) - 12868);
        return p;
    endfunction

    task automatic wait_drained();
        @(posedge clk);
        while (pose_q.size() != 0 || in_valid || cmd_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int n);
        repeat (n) pose_q.push_back(rand_pose());
        wait_drained();
    endtask

    initial begin
        cfg_copy.goal_x = RST_GOAL_X;
        cfg_copy.goal_y = RST_GOAL_Y;
        cfg_copy.prop_gain = RST_PROP_GAIN;
        cfg_copy.integral_gain = RST_INTEGRAL_GAIN;
        cfg_copy.derivative_gain = RST_DERIV_GAIN;
        cfg_copy.arrive_radius = RST_ARRIVE_RADIUS;
        cfg_copy.cruise_speed = RST_CRUISE_SPEED;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed poses against the reset target (8.0, 8.0), radius 0.5
        add_pose(2048, 2048, 0);
        add_pose(4096, 2048, 0);
        add_pose(2048 + 128, 2048, 0);
        add_pose(2048 - 129, 2048, 0);
        add_pose(2048 - 90, 2048 - 90, 0);
        add_pose(2048, 0, 0);
        add_pose(2048, 4096, 0);
        add_pose(-32768, -32768, -32768);
        add_pose(32767, 32767, 32767);
        add_pose(32767, -32768, -32768);
        add_pose(-32768, 32767, 32767);
        add_pose(4096, 4096, 32767);
        add_pose(4096, 0, -32768);
        add_pose(0, 2048, 12868);
        add_pose(0, 0, -12868);
        add_pose(2048, 2048, 32767);
        add_pose(2048, 2048, -32768);
        add_pose(2047, 2048, 1);
        add_pose(2049, 2047, -1);
        add_pose(2049, 2049, 0);
        wait_drained();
        run_random(200);

        set_config(16'h8000, 16'h7FFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 15'h7FFF, 15'h7FFF);
        add_pose(-32768, 32767, 0);
        add_pose(32767, -32768, 32767);
        add_pose(32767, 32767, -32768);
        wait_drained();
        run_random(200);

        set_config(16'h7FFF, 16'h8000, 24'd0, 24'd0, 24'd0, 15'd0, 15'd0);
        add_pose(32767, -32768, 5);
        add_pose(-32768, 32767, -5);
        wait_drained();
        run_random(200);

        // back-pressure: sink holds off while the source keeps offering
        rand_config(1'b0);
        src_idle_pct <= 0;
        hold_len <= 700;
        hold_token <= ~hold_token;
        repeat (40) pose_q.push_back(rand_pose());
        wait_drained();
        run_random(40);
        src_idle_pct <= 35;

        rand_config(1'b0);
        run_random(200);

        rand_config(1'b1);
        src_idle_pct <= 0;
        sink_idle_pct <= 0;
        run_random(200);
        src_idle_pct <= 35;
        sink_idle_pct <= 35;

        rand_config(1'b0);
        run_random(200);

        // target straight behind with the heading pinned at -8
        set_config(16'd0, 16'd0, RST_PROP_GAIN, RST_INTEGRAL_GAIN, RST_DERIV_GAIN,
            RST_ARRIVE_RADIUS, RST_CRUISE_SPEED);
        src_idle_pct <= 0;
        sink_idle_pct <= 0;
        repeat (100) add_pose(int'($urandom_range(256, 32767)), 0, -32768);
        wait_drained();
        src_idle_pct <= 35;
        sink_idle_pct <= 35;

        rand_config(1'b1);
        run_random(150);
        rand_config(1'b0);
        run_random(150);

        repeat (60) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #(4_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/pht_pkg.sv
hdl/pht_regs.sv
hdl/pht_ctrl.sv
hdl/pht_dp.sv
hdl/pid_heading_to_target.sv
bench/pid_heading_to_target_test.sv
